// ----- rtl/stereo_capture_peak_meter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the capture peak meter
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_CAPTURE_PEAK_METER_UNIT_ASSERT_SVH
`define STEREO_CAPTURE_PEAK_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/scpm_pkg.sv -----
// ----------------------------------------------------------------------------
// scpm_pkg
// Shared constants, codes, types and helpers of the capture peak meter.
// ----------------------------------------------------------------------------
`default_nettype none

package scpm_pkg;

    localparam int BLOCK_FRAMES = 64;
    localparam int NUM_DEV      = 2;
    localparam int CNT_W        = $clog2(BLOCK_FRAMES + 1);

    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

    // request function codes
    localparam logic [1:0] FN_FRAME = 2'd0;
    localparam logic [1:0] FN_EOB   = 2'd1;
    localparam logic [1:0] FN_STATS = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_FRAME = 3'd0;
    localparam logic [2:0] KIND_PAD   = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_STATS = 3'd3;
    localparam logic [2:0] KIND_DROP  = 3'd4;

    typedef struct packed {
        logic       load;        // load the result register
        logic [2:0] kind;
        logic       last;
        logic       frame_upd;   // raise peaks, count the frame
        logic       blk_end;     // restart the block count
        logic       starve_inc;
        logic       peak_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic             full;
        logic [CNT_W-1:0] got;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic              dev;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [15:0]       peak_left;
        logic [15:0]       peak_right;
        logic [15:0]       peak_mono;
        logic [31:0]       starve_count;
        logic              starved;
        logic              last;
    } rsp_t;

    function automatic logic signed [15:0] negate_sat(input logic signed [15:0] v);
        logic signed [15:0] r;
        begin
            r = (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
            return r;
        end
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] r;
        begin
            r = v[15] ? 16'(-v) : 16'(v);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/scpm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// scpm_cmd_if
// Request channel: function code, device slot and one stereo frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface scpm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic               slot;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, output func, output slot, output left_in,
                    output right_in, input ready);
    modport sink   (input valid, input func, input slot, input left_in,
                    input right_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/scpm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scpm_rsp_if
// Result channel: passed frames, padding, block markers and peak stats.
// ----------------------------------------------------------------------------
`default_nettype none

interface scpm_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic               dev;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [15:0]        peak_left;
    logic [15:0]        peak_right;
    logic [15:0]        peak_mono;
    logic [31:0]        starve_count;
    logic               starved;
    logic               last;

    modport source (output valid, output kind, output dev, output left_out,
                    output right_out, output peak_left, output peak_right,
                    output peak_mono, output starve_count, output starved,
                    output last, input ready);
    modport sink   (input valid, input kind, input dev, input left_out,
                    input right_out, input peak_left, input peak_right,
                    input peak_mono, input starve_count, input starved,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/scpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// scpm_ctrl
// Request decode, padding and stats sequencer, result register valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_capture_peak_meter_unit_assert.svh"

module scpm_ctrl import scpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_func,
    input  wire logic       in_slot,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         dp_cmd,
    output logic            dev_sel
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PAD   = 2'd1;
    localparam logic [1:0] ST_STATS = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             slot_reg, slot_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic [CNT_W-1:0] pad_first;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    // padding results still owed after the first one
    assign pad_first = CNT_W'(BLOCK_FRAMES) - stat.got - CNT_W'(1);

    always_comb
    begin
        unique case (state_reg)
            ST_PAD:   dev_sel = slot_reg;
            ST_STATS: dev_sel = 1'(NUM_DEV - 1);
            default:  dev_sel = (in_func == FN_STATS) ? 1'b0 : in_slot;
        endcase
    end

    always_comb
    begin
        dp_cmd         = '0;
        in_ready       = 1'b0;
        state_next     = state_reg;
        slot_next      = slot_reg;
        remaining_next = remaining_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    slot_next = in_slot;
                    unique case (in_func)
                        FN_FRAME:
                        begin
                            dp_cmd.load = 1'b1;
                            dp_cmd.last = 1'b1;
                            if (stat.full)
                            begin
                                dp_cmd.kind = KIND_DROP;
                            end
                            else
                            begin
                                dp_cmd.kind      = KIND_FRAME;
                                dp_cmd.frame_upd = 1'b1;
                            end
                        end
                        FN_EOB:
                        begin
                            dp_cmd.load    = 1'b1;
                            dp_cmd.blk_end = 1'b1;
                            if (stat.full)
                            begin
                                dp_cmd.kind = KIND_DONE;
                                dp_cmd.last = 1'b1;
                            end
                            else
                            begin
                                dp_cmd.kind       = KIND_PAD;
                                dp_cmd.starve_inc = 1'b1;
                                dp_cmd.last       = (pad_first == '0);
                                remaining_next    = pad_first;
                                if (pad_first != '0)
                                begin
                                    state_next = ST_PAD;
                                end
                            end
                        end
                        FN_STATS:
                        begin
                            dp_cmd.load     = 1'b1;
                            dp_cmd.kind     = KIND_STATS;
                            dp_cmd.peak_clr = 1'b1;
                            dp_cmd.last     = (NUM_DEV == 1);
                            if (NUM_DEV > 1)
                            begin
                                state_next = ST_STATS;
                            end
                        end
                        default:
                        begin
                            // drop the unused function code
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                if (slot_free)
                begin
                    dp_cmd.load    = 1'b1;
                    dp_cmd.kind    = KIND_PAD;
                    dp_cmd.last    = (remaining_reg == CNT_W'(1));
                    remaining_next = remaining_reg - CNT_W'(1);
                    if (remaining_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATS:
            begin
                if (slot_free)
                begin
                    dp_cmd.load     = 1'b1;
                    dp_cmd.kind     = KIND_STATS;
                    dp_cmd.peak_clr = 1'b1;
                    dp_cmd.last     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= 1'b0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SCPM_ASSERT_NOW(a_pad_count_live, state_reg == ST_PAD, remaining_reg != '0,
        "padding state with nothing left to send")
    `SCPM_ASSERT_NOW(a_no_overwrite, dp_cmd.load, !out_valid_reg || out_ready,
        "result register loaded while a result is pending")
    `SCPM_ASSERT_NEXT(a_pad_ends_idle, state_reg == ST_PAD && dp_cmd.load && dp_cmd.last,
        state_reg == ST_IDLE, "padding burst did not return to idle")

endmodule

`default_nettype wire

// ----- rtl/scpm_dp.sv -----
// ----------------------------------------------------------------------------
// scpm_dp
// Per-device peak holds, block counts, starve counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scpm_dp import scpm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_wdata,
    input  wire dp_cmd_t            dp_cmd,
    input  wire logic               dev_sel,
    input  wire logic signed [15:0] left_in,
    input  wire logic signed [15:0] right_in,
    output dp_stat_t                stat,
    output rsp_t                    rsp_data
);

    logic [1:0]       invert_reg;
    logic [CNT_W-1:0] frames_reg [NUM_DEV];
    logic [15:0]      hold_left_reg [NUM_DEV];
    logic [15:0]      hold_right_reg [NUM_DEV];
    logic [15:0]      hold_mono_reg [NUM_DEV];
    logic [31:0]      starves_reg [NUM_DEV];
    rsp_t             rsp_reg, rsp_next;

    logic signed [15:0] right_adj;
    logic signed [16:0] sum;
    logic [16:0]        sum_mag;
    logic [15:0]        mag_l, mag_r, mag_m;
    logic [31:0]        starve_now;

    assign right_adj = invert_reg[dev_sel] ? negate_sat(right_in) : right_in;
    assign sum       = 17'(left_in) + 17'(right_adj);
    // |trunc(s/2)| is |s| halved
    assign sum_mag   = sum[16] ? 17'(-sum) : 17'(sum);
    assign mag_l     = mag16(left_in);
    assign mag_r     = mag16(right_adj);
    assign mag_m     = sum_mag[16:1];

    assign stat.got  = frames_reg[dev_sel];
    assign stat.full = (frames_reg[dev_sel] >= CNT_W'(BLOCK_FRAMES));

    assign starve_now = dp_cmd.starve_inc ? starves_reg[dev_sel] + 32'd1
                                          : starves_reg[dev_sel];

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.kind = dp_cmd.kind;
        rsp_next.dev  = dev_sel;
        rsp_next.last = dp_cmd.last;
        unique case (dp_cmd.kind)
            KIND_FRAME:
            begin
                rsp_next.left_out  = left_in;
                rsp_next.right_out = right_adj;
            end
            KIND_PAD:
            begin
                rsp_next.starve_count = starve_now;
                rsp_next.starved      = 1'b1;
            end
            KIND_DONE:
            begin
                rsp_next.starve_count = starve_now;
            end
            KIND_STATS:
            begin
                rsp_next.peak_left    = hold_left_reg[dev_sel];
                rsp_next.peak_right   = hold_right_reg[dev_sel];
                rsp_next.peak_mono    = hold_mono_reg[dev_sel];
                rsp_next.starve_count = starve_now;
            end
            default:
            begin
                // dropped frame carries zeros
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 2'b01;
            for (int d = 0; d < NUM_DEV; d++)
            begin
                frames_reg[d]     <= '0;
                hold_left_reg[d]  <= '0;
                hold_right_reg[d] <= '0;
                hold_mono_reg[d]  <= '0;
                starves_reg[d]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                invert_reg <= cfg_wdata;
            end
            if (dp_cmd.frame_upd)
            begin
                frames_reg[dev_sel] <= frames_reg[dev_sel] + CNT_W'(1);
                if (mag_l > hold_left_reg[dev_sel])
                begin
                    hold_left_reg[dev_sel] <= mag_l;
                end
                if (mag_r > hold_right_reg[dev_sel])
                begin
                    hold_right_reg[dev_sel] <= mag_r;
                end
                if (mag_m > hold_mono_reg[dev_sel])
                begin
                    hold_mono_reg[dev_sel] <= mag_m;
                end
            end
            if (dp_cmd.blk_end)
            begin
                frames_reg[dev_sel] <= '0;
            end
            if (dp_cmd.starve_inc)
            begin
                starves_reg[dev_sel] <= starve_now;
            end
            if (dp_cmd.peak_clr)
            begin
                hold_left_reg[dev_sel]  <= '0;
                hold_right_reg[dev_sel] <= '0;
                hold_mono_reg[dev_sel]  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stereo_capture_peak_meter_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_capture_peak_meter_unit
// Stereo capture frame pass-through with held peaks, block padding and stats.
//
//   Channel   Dir   Handshake      Carries
//   cmd       in    valid/ready    func, slot, left_in, right_in
//   rsp       out   valid/ready    kind, dev, samples, peaks, starve count
//   cfg       in    cfg_we only    invert_mask (2 bits)
//
// A frame, dropped frame or block-complete marker gives one result, an ignored
// request gives none, and a stats read gives one result per device.
// A short block end gives BLOCK_FRAMES - frames held padding results,
// issued by the controller from a down-counter.
// Reset clears peaks, counts and starve counters; invert_mask resets to 1.
// A stalled rsp holds the result register and the controller waits on it;
// a new request is taken in the same cycle that the pending result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_capture_peak_meter_unit import scpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    scpm_cmd_if.sink        cmd,
    scpm_rsp_if.source      rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;
    rsp_t     rsp_data;
    logic     dev_sel;

    scpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_func   (cmd.func),
        .in_slot   (cmd.slot),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .dp_cmd    (dp_cmd),
        .dev_sel   (dev_sel)
    );

    scpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dp_cmd    (dp_cmd),
        .dev_sel   (dev_sel),
        .left_in   (cmd.left_in),
        .right_in  (cmd.right_in),
        .stat      (stat),
        .rsp_data  (rsp_data)
    );

    assign rsp.kind         = rsp_data.kind;
    assign rsp.dev          = rsp_data.dev;
    assign rsp.left_out     = rsp_data.left_out;
    assign rsp.right_out    = rsp_data.right_out;
    assign rsp.peak_left    = rsp_data.peak_left;
    assign rsp.peak_right   = rsp_data.peak_right;
    assign rsp.peak_mono    = rsp_data.peak_mono;
    assign rsp.starve_count = rsp_data.starve_count;
    assign rsp.starved      = rsp_data.starved;
    assign rsp.last         = rsp_data.last;

endmodule

`default_nettype wire
